/* design/utf8_pkg.sv */
package utf8_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] code_t;
	typedef logic [1:0]  err_t;
	typedef logic [2:0]  count_t;

	localparam err_t ERR_NONE = 2'd0;
	localparam err_t ERR_LEAD = 2'd1;
	localparam err_t ERR_CONT = 2'd2;

	localparam byte_t LEAD6_MIN = 8'hFC;
	localparam byte_t LEAD5_MIN = 8'hF8;
	localparam byte_t LEAD4_MIN = 8'hF0;
	localparam byte_t LEAD3_MIN = 8'hE0;
	localparam byte_t LEAD2_MIN = 8'hC0;
	localparam byte_t CONT_MIN  = 8'h80;

	localparam count_t MAX_REMAINING = 3'd5;

endpackage

/* design/utf8_byte_stream_decoder.sv */
// Byte-serial decoder for extended UTF-8 (one- to six-byte sequences).
//
// Input channel: in_valid / in_stall with byte_in, one raw byte per item.
// Output channel: out_valid / out_stall with code_point and error_code.
// An item moves at a rising edge where valid is high and stall is low.
//
// A lead or continuation byte that neither completes a sequence nor is
// malformed produces no result. A completed sequence yields the code point
// with error_code 0. A continuation byte seen while idle yields error 1; a
// non-continuation byte inside a sequence yields error 2, is consumed, and
// the decoder returns to idle. Error results carry code_point 0.
//
// Throughput is one byte per clock while in_stall is low: the input register
// feeds a single shift-and-mask stage into the result register, which drives
// out_valid once the last byte of a sequence has passed through both.
// When out_stall holds a result, bytes that produce no result still pass;
// a byte that would produce one waits in the input register and in_stall
// rises. Reset (arst_n low) empties both registers and returns to idle.
module utf8_byte_stream_decoder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  utf8_pkg::byte_t  byte_in,
	output logic             out_valid,
	input  logic             out_stall,
	output utf8_pkg::code_t  code_point,
	output utf8_pkg::err_t   error_code
);
	import utf8_pkg::*;

	logic   valid_s1;
	byte_t  byte_s1;
	count_t rem_q;
	code_t  part_q;
	logic   out_valid_q;
	code_t  cp_q;
	err_t   err_q;

	count_t rem_d;
	count_t rem_dec;
	code_t  part_d;
	code_t  slot;
	code_t  merged;
	logic   res_valid;
	code_t  res_cp;
	err_t   res_err;
	logic   out_free;
	logic   advance;

	// Decode step on the registered byte
	always_comb begin
		rem_d     = rem_q;
		part_d    = part_q;
		res_valid = 1'b0;
		res_cp    = '0;
		res_err   = ERR_NONE;
		rem_dec   = rem_q - 3'd1;
		slot      = '0;
		case (rem_dec)
			3'd0:    slot = {26'b0, byte_s1[5:0]};
			3'd1:    slot = {20'b0, byte_s1[5:0], 6'b0};
			3'd2:    slot = {14'b0, byte_s1[5:0], 12'b0};
			3'd3:    slot = {8'b0, byte_s1[5:0], 18'b0};
			3'd4:    slot = {2'b0, byte_s1[5:0], 24'b0};
			default: slot = '0;
		endcase
		merged = part_q | slot;

		if (rem_q != 3'd0) begin
			if (byte_s1 >= CONT_MIN && byte_s1 < LEAD2_MIN) begin
				rem_d = rem_dec;
				if (rem_dec == 3'd0) begin
					part_d    = '0;
					res_valid = 1'b1;
					res_cp    = merged;
				end else begin
					part_d = merged;
				end
			end else begin
				// drop the sequence and the offending byte
				rem_d     = '0;
				part_d    = '0;
				res_valid = 1'b1;
				res_err   = ERR_CONT;
			end
		end else if (byte_s1 >= LEAD6_MIN) begin
			part_d = {byte_s1[1:0], 30'b0};
			rem_d  = 3'd5;
		end else if (byte_s1 >= LEAD5_MIN) begin
			part_d = {6'b0, byte_s1[1:0], 24'b0};
			rem_d  = 3'd4;
		end else if (byte_s1 >= LEAD4_MIN) begin
			part_d = {11'b0, byte_s1[2:0], 18'b0};
			rem_d  = 3'd3;
		end else if (byte_s1 >= LEAD3_MIN) begin
			part_d = {16'b0, byte_s1[3:0], 12'b0};
			rem_d  = 3'd2;
		end else if (byte_s1 >= LEAD2_MIN) begin
			part_d = {21'b0, byte_s1[4:0], 6'b0};
			rem_d  = 3'd1;
		end else if (byte_s1 >= CONT_MIN) begin
			part_d    = '0;
			res_valid = 1'b1;
			res_err   = ERR_LEAD;
		end else begin
			part_d    = '0;
			res_valid = 1'b1;
			res_cp    = {24'b0, byte_s1};
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	// a byte with no result never waits on the output side
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			part_q <= '0;
		end else if (advance) begin
			rem_q  <= rem_d;
			part_q <= part_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			cp_q  <= res_cp;
			err_q <= res_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = cp_q;
	assign error_code = err_q;

`ifndef ASSERT_OFF
	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q != ERR_NONE |-> cp_q == '0)
		else $error("error result with nonzero code point");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> err_q == ERR_NONE || err_q == ERR_LEAD || err_q == ERR_CONT)
		else $error("undefined error code");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= MAX_REMAINING)
		else $error("remaining count out of range");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q == 3'd0 |-> part_q == '0)
		else $error("partial value not cleared while idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(cp_q) && $stable(err_q))
		else $error("stalled result overwritten");
`endif

endmodule
